### design/gbr_pkg.sv
package gbr_pkg;

    localparam int C_K      = 7;
    localparam int C_HALF   = C_K / 2;
    localparam int C_LB     = C_K - 1;
    localparam int C_MAXW   = 512;
    localparam int C_MAXH   = 512;
    localparam int C_FRAC   = 16;
    localparam int C_PXW    = 24;
    localparam int C_ACCW   = 26;
    localparam int C_CW     = 12;
    localparam int C_CRDW   = 9;
    localparam int C_REGW   = 10;
    localparam int C_SLOTW  = 3;
    localparam int C_KIW    = 3;

    // register indexes of the configuration port
    localparam logic C_REG_WIDTH  = 1'b0;
    localparam logic C_REG_HEIGHT = 1'b1;

    typedef logic [C_PXW-1:0]  t_px;
    typedef t_px [C_K-1:0][C_K-1:0] t_win;
    typedef logic [C_ACCW-1:0] t_acc;
    typedef logic [C_CW-1:0]   t_coef;

    typedef struct packed {
        logic                valid;
        logic                last;
        logic [C_CRDW-1:0]   y;
        logic [C_CRDW-1:0]   x;
        t_acc [2:0]          acc;
        t_win                pix;
    } t_job;

    // round(e4 / 10000 * 2^C_FRAC)
    function automatic t_coef quant(input int e4);
        return t_coef'(((e4 << C_FRAC) + 5000) / 10000);
    endfunction

    localparam t_coef C_COEF [C_K][C_K] = '{
        '{quant(91),  quant(132), quant(165), quant(178), quant(165), quant(132), quant(91)},
        '{quant(132), quant(192), quant(239), quant(258), quant(239), quant(192), quant(132)},
        '{quant(165), quant(239), quant(299), quant(322), quant(299), quant(239), quant(165)},
        '{quant(178), quant(258), quant(322), quant(347), quant(322), quant(258), quant(178)},
        '{quant(165), quant(239), quant(299), quant(322), quant(299), quant(239), quant(165)},
        '{quant(132), quant(192), quant(239), quant(258), quant(239), quant(192), quant(132)},
        '{quant(91),  quant(132), quant(165), quant(178), quant(165), quant(132), quant(91)}
    };

endpackage

### design/gbr_ram.sv
module gbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when both ports hit one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/gbr_cell.sv
module gbr_cell import gbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [C_KIW-1:0] i_row_idx,
    input  t_job             i_job,
    output t_job             o_job
);

    t_job r_job;
    t_job n_job;

    // add this kernel row, then hand the remaining rows on one place down
    always_comb begin
        n_job = i_job;
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < C_K; j++) begin
                n_job.acc[ch] = n_job.acc[ch]
                    + C_ACCW'(i_job.pix[0][j][8*ch +: 8]) * C_ACCW'(C_COEF[i_row_idx][j]);
            end
        end
        for (int i = 0; i < C_K - 1; i++) begin
            n_job.pix[i] = i_job.pix[i+1];
        end
        n_job.pix[C_K-1] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.valid <= 1'b0;
        end else if (i_en) begin
            r_job <= n_job;
        end
    end

    assign o_job = r_job;

endmodule

### design/gaussian_blur_7x7_rgb.sv
// channel   dir  handshake                      payload (lowest bit first)
// s_axis    in   i_s_tvalid / o_s_tready        tdata: red, green, blue
// m_axis    out  o_m_tvalid / i_m_tready        tdata: row, col, red, green, blue; tlast
// cfg       in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// One pixel a cycle while each pixel gives at most one result and the output does not
// stall; a pixel that gives several results holds the input while the window issues them
// one a cycle unless the output stalls (up to 4 at a row end or in the last row, 16 at
// frame end). Results pass line buffer read, window, issue, seven row cells, output register.
// Synchronous active-low reset clears control only; a stall on the output freezes issue,
// row cells and output register, and, while a result waits to issue, the window and the input.
module gaussian_blur_7x7_rgb import gbr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [23:0]       i_s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [47:0]       o_m_tdata,   // row[8:0], col[17:9], red, green, blue, zero pad
    output logic              o_m_tlast,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [C_REGW-1:0] i_cfg_data
);

    logic [C_REGW-1:0]  r_cfg_w, r_cfg_h;
    logic [C_CRDW-1:0]  wm1, hm1;
    logic [C_CRDW-1:0]  r_row, r_col;
    logic [C_SLOTW-1:0] r_slot;
    logic               acc_in, en, wmove, issue_last;

    always_comb begin
        if (r_cfg_w == '0) begin
            wm1 = '0;
        end else if (r_cfg_w > C_REGW'(C_MAXW)) begin
            wm1 = C_CRDW'(C_MAXW - 1);
        end else begin
            wm1 = C_CRDW'(r_cfg_w - 1'b1);
        end
        if (r_cfg_h == '0) begin
            hm1 = '0;
        end else if (r_cfg_h > C_REGW'(C_MAXH)) begin
            hm1 = C_CRDW'(C_MAXH - 1);
        end else begin
            hm1 = C_CRDW'(r_cfg_h - 1'b1);
        end
    end

    // ---------------- input counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= C_REGW'(C_MAXW);
            r_cfg_h <= C_REGW'(C_MAXH);
            r_row   <= '0;
            r_col   <= '0;
            r_slot  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_WIDTH:  r_cfg_w <= i_cfg_data;
                C_REG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (acc_in) begin
            if (r_col == wm1) begin
                r_col <= '0;
                if (r_row == hm1) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + 1'b1;
                    r_slot <= (r_slot == C_SLOTW'(C_LB - 1)) ? '0 : r_slot + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // ---------------- line buffers
    t_px rd [C_LB];

    for (genvar g = 0; g < C_LB; g++) begin : g_lb
        gbr_ram #(.WIDTH(C_PXW), .DEPTH(C_MAXW)) u_ram (
            .i_clk   (i_clk),
            .i_we    (acc_in && (r_slot == C_SLOTW'(g))),
            .i_waddr (r_col),
            .i_wdata (i_s_tdata),
            .i_re    (acc_in),
            .i_raddr (r_col),
            .o_rdata (rd[g])
        );
    end

    // ---------------- read stage
    logic               r_a_valid, r_a_rlast, r_a_clast;
    t_px                r_a_px;
    logic [C_SLOTW-1:0] r_a_slot;
    logic [C_CRDW-1:0]  r_a_row, r_a_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (acc_in) begin
            r_a_valid <= 1'b1;
        end else if (wmove) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_px    <= i_s_tdata;
            r_a_slot  <= r_slot;
            r_a_row   <= r_row;
            r_a_col   <= r_col;
            r_a_rlast <= (r_row == hm1);
            r_a_clast <= (r_col == wm1);
        end
    end

    // ---------------- window and job sequencer
    t_win              r_win;
    logic              r_pend;
    logic [C_CRDW-1:0] r_jy, r_jx, r_xlo, r_xhi, r_yhi, r_br, r_bc;
    logic              yv, xv;
    logic [C_CRDW-1:0] ylo, yhi, xlo, xhi;
    logic [C_SLOTW:0]  sidx [C_LB];

    assign en         = !o_m_tvalid || i_m_tready;
    assign issue_last = r_pend && (r_jy == r_yhi) && (r_jx == r_xhi);
    assign wmove      = r_a_valid && (!r_pend || (en && issue_last));
    assign o_s_tready = !r_a_valid || wmove;
    assign acc_in     = i_s_tvalid && o_s_tready && !i_cfg_we;

    always_comb begin
        yv  = 1'b1;
        ylo = r_a_row - C_CRDW'(C_HALF);
        yhi = ylo;
        if (r_a_rlast) begin
            ylo = (r_a_row >= C_CRDW'(C_HALF)) ? r_a_row - C_CRDW'(C_HALF) : '0;
            yhi = r_a_row;
        end else if (r_a_row < C_CRDW'(C_HALF)) begin
            yv = 1'b0;
        end
        xv  = 1'b1;
        xlo = r_a_col - C_CRDW'(C_HALF);
        xhi = xlo;
        if (r_a_clast) begin
            xlo = (r_a_col >= C_CRDW'(C_HALF)) ? r_a_col - C_CRDW'(C_HALF) : '0;
            xhi = r_a_col;
        end else if (r_a_col < C_CRDW'(C_HALF)) begin
            xv = 1'b0;
        end
        for (int i = 0; i < C_LB; i++) begin
            sidx[i] = {1'b0, r_a_slot} + (C_SLOTW+1)'(i);
            if (sidx[i] >= (C_SLOTW+1)'(C_LB)) begin
                sidx[i] = sidx[i] - (C_SLOTW+1)'(C_LB);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wmove) begin
            for (int i = 0; i < C_K; i++) begin
                for (int k = 0; k < C_K - 1; k++) begin
                    r_win[i][k] <= r_win[i][k+1];
                end
            end
            for (int i = 0; i < C_LB; i++) begin
                r_win[i][C_K-1] <= rd[sidx[i][C_SLOTW-1:0]];
            end
            r_win[C_K-1][C_K-1] <= r_a_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (wmove) begin
            r_pend <= yv && xv;
        end else if (en && issue_last) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wmove) begin
            r_jy  <= ylo;
            r_jx  <= xlo;
            r_xlo <= xlo;
            r_xhi <= xhi;
            r_yhi <= yhi;
            r_br  <= r_a_row;
            r_bc  <= r_a_col;
        end else if (en && r_pend) begin
            if (r_jx == r_xhi) begin
                r_jx <= r_xlo;
                r_jy <= r_jy + 1'b1;
            end else begin
                r_jx <= r_jx + 1'b1;
            end
        end
    end

    // ---------------- issue: pick the kernel-aligned, bounds-masked window
    t_job              n_issue, r_issue;
    logic [C_CRDW:0]   ty, tx;
    logic [C_KIW:0]    si, sj;

    always_comb begin
        n_issue       = '0;
        n_issue.valid = r_pend;
        n_issue.last  = issue_last;
        n_issue.y     = r_jy;
        n_issue.x     = r_jx;
        ty = {1'b0, r_jy} + (C_CRDW+1)'(C_HALF) - {1'b0, r_br};
        tx = {1'b0, r_jx} + (C_CRDW+1)'(C_HALF) - {1'b0, r_bc};
        si = '0;
        sj = '0;
        for (int i = 0; i < C_K; i++) begin
            for (int j = 0; j < C_K; j++) begin
                si = (C_KIW+1)'(i) + (C_KIW+1)'(ty[1:0]);
                sj = (C_KIW+1)'(j) + (C_KIW+1)'(tx[1:0]);
                if ((si < (C_KIW+1)'(C_K)) && (sj < (C_KIW+1)'(C_K))
                        && ({1'b0, r_jy} + (C_CRDW+1)'(i) >= (C_CRDW+1)'(C_HALF))
                        && ({1'b0, r_jx} + (C_CRDW+1)'(j) >= (C_CRDW+1)'(C_HALF))) begin
                    n_issue.pix[i][j] = r_win[si[C_KIW-1:0]][sj[C_KIW-1:0]];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue.valid <= 1'b0;
        end else if (en) begin
            r_issue <= n_issue;
        end
    end

    // ---------------- row cells
    t_job chain [C_K+1];

    assign chain[0] = r_issue;

    for (genvar g = 0; g < C_K; g++) begin : g_cell
        gbr_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_row_idx (C_KIW'(g)),
            .i_job     (chain[g]),
            .o_job     (chain[g+1])
        );
    end

    // ---------------- output register
    logic       r_out_valid, r_out_last;
    logic [7:0] r_out_ch [3];
    logic [C_CRDW-1:0] r_out_y, r_out_x;
    logic [C_ACCW-C_FRAC-1:0] sh [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sh[ch] = chain[C_K].acc[ch][C_ACCW-1:C_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain[C_K].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_last <= chain[C_K].last;
            r_out_y    <= chain[C_K].y;
            r_out_x    <= chain[C_K].x;
            for (int ch = 0; ch < 3; ch++) begin
                r_out_ch[ch] <= (sh[ch] > (C_ACCW-C_FRAC)'(255)) ? 8'hFF : sh[ch][7:0];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'b0, r_out_ch[2], r_out_ch[1], r_out_ch[0], r_out_x, r_out_y};

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < C_SLOTW'(C_LB))
        else $error("line buffer slot out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= wm1 || $past(i_cfg_we))
        else $error("column counter beyond frame width");

    a_job_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_jy <= r_yhi && r_jx <= r_xhi))
        else $error("issued result outside its run");

    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !issue_last && r_a_valid) |-> !o_s_tready)
        else $error("input taken while window still issuing");
`endif

endmodule
